// ===== hw/rtl/tilt_pkg.sv =====
// Package: shared constants, codes and types of the tilt angle pipeline.
`default_nettype none

package tilt_pkg;

   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int COEF_FRAC_BITS_DEF = 14;

   localparam int ROW_BITS     = 48;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_HOUSING = 2'd1;
   localparam logic [1:0] MODE_BOTH    = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOUSING0 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOUSING1 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOUSING2 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHIP0    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHIP1    = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHIP2    = 3'd6;

   // normalized operand width of the arctangent units
   localparam int NRM_BITS   = 30;
   localparam int NORM_STEPS = 5;
   localparam int CRD_BITS   = 33;
   localparam int ANG_BITS   = 32;

   localparam int CORDIC_STEPS = 24;
   // atan(2^-i) in 2^-16 centidegree
   localparam int ATAN_TAB [CORDIC_STEPS] = '{
      294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
      5866610, 2933484, 1466764, 733385, 366693, 183346,
      91673, 45837, 22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45
   };

   localparam int ANGLE_RIGHT = 9000;
   localparam int ANGLE_HALF  = 18000;

   typedef struct packed {
      logic bad;
      logic wx_pos;
      logic wy_pos;
      logic wy_neg;
      logic wz_pos;
      logic wz_neg;
   } flag_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tilt_angle_from_gravity.sv =====
// Top level: pipelined roll and pitch from one rotated accelerometer sample.
//
//  channel | direction | payload                                | handshake
//  req     | in        | accel_x, accel_y, accel_z              | req_valid / req_ready
//  rsp     | out       | angle_x, angle_y, invalid              | rsp_valid / rsp_ready
//  csr     | in        | csr_index (0..6), csr_data (48 bit)    | csr_valid / csr_ready
//
// One item per cycle while the output is not stalled; the stages are four matrix stages, magnitude,
// square, sum, SAMPLE_BITS + 6 root stages, five normalize steps, 24 CORDIC steps, output.
// Each stage holds its own valid bit; a stage advances when it or a later stage
// has room, so a stalled result does not block the bubbles behind it.
// Reset clears valid bits and loads mode 2 with identity matrices. csr_ready is always high.
`default_nettype none

module tilt_angle_from_gravity
   import tilt_pkg::*;
#(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_z,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic signed [15:0]            rsp_angle_x,
   output      logic signed [14:0]            rsp_angle_y,
   output      logic                          rsp_invalid,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [ROW_BITS-1:0]           csr_data
);

   localparam int CB  = COEF_FRAC_BITS + 2;
   localparam int PW  = SAMPLE_BITS + CB;
   localparam int V1  = SAMPLE_BITS + 3;
   localparam int QW  = V1 + CB;
   localparam int AW  = QW + 2;
   localparam int V2  = SAMPLE_BITS + 6;
   localparam int MW  = V2 - 1;
   localparam int SQW = 2 * MW;
   localparam int NW  = 2 * MW + 2;
   localparam int RW  = MW + 1;
   localparam int RXW = 3 * CB + ROW_BITS;

   localparam int ST_HPROD = 1;
   localparam int ST_HSUM  = 2;
   localparam int ST_SPROD = 3;
   localparam int ST_SSUM  = 4;
   localparam int ST_MAG   = 5;
   localparam int ST_SQR   = 6;
   localparam int ST_ADD   = 7;
   localparam int ST_ROOT  = 8;
   localparam int ST_NORM  = ST_ROOT + RW;
   localparam int ST_CORD  = ST_NORM + NORM_STEPS;
   localparam int ST_OUT   = ST_CORD + CORDIC_STEPS;
   localparam int NS       = ST_OUT;

   localparam logic [RXW-1:0] ONE_ROW2 = RXW'(1) << COEF_FRAC_BITS;
   localparam logic [RXW-1:0] ONE_ROW1 = ONE_ROW2 << CB;
   localparam logic [RXW-1:0] ONE_ROW0 = ONE_ROW2 << (2 * CB);

   function automatic logic signed [CB-1:0] coef_of(input logic [ROW_BITS-1:0] row,
                                                    input int col);
      logic [RXW-1:0] ext;
      ext = RXW'(row);
      return signed'(ext[(2 - col) * CB +: CB]);
   endfunction

   function automatic logic signed [AW-1:0] round_q(input logic signed [AW-1:0] a);
      logic [AW-1:0] m;
      m = a[AW-1] ? AW'(-a) : AW'(a);
      m = (m + (AW'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
      return a[AW-1] ? -signed'(m) : signed'(m);
   endfunction

   function automatic logic [13:0] to_cdeg(input logic signed [ANG_BITS-1:0] z);
      logic signed [ANG_BITS-1:0] q;
      q = (z + 32'sd32768) >>> 16;
      if (q < 0) begin
         return '0;
      end else if (q > ANGLE_RIGHT) begin
         return 14'(ANGLE_RIGHT);
      end
      return 14'(q);
   endfunction

   // ---------------- configuration ----------------
   logic [1:0]          mode_ff;
   logic [ROW_BITS-1:0] housing_ff [3];
   logic [ROW_BITS-1:0] ship_ff [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_BOTH;
         housing_ff[0] <= ONE_ROW0[ROW_BITS-1:0];
         housing_ff[1] <= ONE_ROW1[ROW_BITS-1:0];
         housing_ff[2] <= ONE_ROW2[ROW_BITS-1:0];
         ship_ff[0]    <= ONE_ROW0[ROW_BITS-1:0];
         ship_ff[1]    <= ONE_ROW1[ROW_BITS-1:0];
         ship_ff[2]    <= ONE_ROW2[ROW_BITS-1:0];
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MODE:     mode_ff       <= csr_data[1:0];
            CSR_HOUSING0: housing_ff[0] <= csr_data;
            CSR_HOUSING1: housing_ff[1] <= csr_data;
            CSR_HOUSING2: housing_ff[2] <= csr_data;
            CSR_SHIP0:    ship_ff[0]    <= csr_data;
            CSR_SHIP1:    ship_ff[1]    <= csr_data;
            CSR_SHIP2:    ship_ff[2]    <= csr_data;
            default:      mode_ff       <= mode_ff;
         endcase
      end
   end

   logic use_housing;
   logic use_ship;
   assign use_housing = (mode_ff == MODE_HOUSING) || (mode_ff == MODE_BOTH);
   assign use_ship    = (mode_ff == MODE_BOTH);

   // ---------------- valid / ready chain ----------------
   logic [NS:1]   vld_ff;
   logic [NS:1]   vld_in;
   logic [NS:0]   vld;
   logic [NS+1:1] rdy;

   assign vld[0]    = req_valid;
   assign vld[NS:1] = vld_ff;
   assign rdy[NS+1] = rsp_ready;
   assign req_ready = rdy[1];
   assign rsp_valid = vld_ff[NS];

   for (genvar k = 1; k <= NS; k++) begin : g_hs
      assign rdy[k]    = !vld_ff[k] || rdy[k+1];
      assign vld_in[k] = rdy[k] ? vld[k-1] : vld_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- housing matrix ----------------
   logic signed [SAMPLE_BITS-1:0] smp [3];
   assign smp[0] = req_accel_x;
   assign smp[1] = req_accel_y;
   assign smp[2] = req_accel_z;

   logic signed [PW-1:0]          hp_ff [3][3];
   logic signed [SAMPLE_BITS-1:0] s1_ff [3];

   always_ff @(posedge clock) begin
      if (rdy[ST_HPROD]) begin
         for (int i = 0; i < 3; i++) begin
            s1_ff[i] <= smp[i];
            for (int j = 0; j < 3; j++) begin
               hp_ff[i][j] <= PW'(coef_of(housing_ff[i], j)) * PW'(smp[j]);
            end
         end
      end
   end

   logic signed [V1-1:0] v1_in [3];
   logic signed [V1-1:0] v1_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v1_in[i] = use_housing
            ? V1'(round_q(AW'(hp_ff[i][0]) + AW'(hp_ff[i][1]) + AW'(hp_ff[i][2])))
            : V1'(s1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_HSUM]) begin
         v1_ff <= v1_in;
      end
   end

   // ---------------- ship matrix ----------------
   logic signed [QW-1:0] sp_ff [3][3];
   logic signed [V1-1:0] v3_ff [3];

   always_ff @(posedge clock) begin
      if (rdy[ST_SPROD]) begin
         for (int i = 0; i < 3; i++) begin
            v3_ff[i] <= v1_ff[i];
            for (int j = 0; j < 3; j++) begin
               sp_ff[i][j] <= QW'(coef_of(ship_ff[i], j)) * QW'(v1_ff[j]);
            end
         end
      end
   end

   logic signed [V2-1:0] v2_in [3];
   logic signed [V2-1:0] v2_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v2_in[i] = use_ship
            ? V2'(round_q(AW'(sp_ff[i][0]) + AW'(sp_ff[i][1]) + AW'(sp_ff[i][2])))
            : V2'(v3_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_SSUM]) begin
         v2_ff <= v2_in;
      end
   end

   // ---------------- negate, magnitudes, flags ----------------
   // w = -v, so signs of w are the opposite of v
   flag_type        fl5_in;
   logic [MW-1:0]   mg5_in [3];
   flag_type        fl5_ff;
   logic [MW-1:0]   mg5_ff [3];

   always_comb begin
      fl5_in.bad    = (v2_ff[0] == 0) && (v2_ff[2] == 0);
      fl5_in.wx_pos = v2_ff[0] < 0;
      fl5_in.wy_pos = v2_ff[1] < 0;
      fl5_in.wy_neg = v2_ff[1] > 0;
      fl5_in.wz_pos = v2_ff[2] < 0;
      fl5_in.wz_neg = v2_ff[2] > 0;
      for (int i = 0; i < 3; i++) begin
         mg5_in[i] = v2_ff[i][V2-1] ? MW'(-v2_ff[i]) : MW'(v2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_MAG]) begin
         fl5_ff <= fl5_in;
         mg5_ff <= mg5_in;
      end
   end

   logic [SQW-1:0] sqx_ff;
   logic [SQW-1:0] sqz_ff;
   flag_type       fl6_ff;
   logic [MW-1:0]  mg6_ff [3];

   always_ff @(posedge clock) begin
      if (rdy[ST_SQR]) begin
         sqx_ff <= SQW'(mg5_ff[0]) * SQW'(mg5_ff[0]);
         sqz_ff <= SQW'(mg5_ff[2]) * SQW'(mg5_ff[2]);
         fl6_ff <= fl5_ff;
         mg6_ff <= mg5_ff;
      end
   end

   logic [NW-1:0] sum_ff;
   flag_type      fl7_ff;
   logic [MW-1:0] mg7_ff [3];

   always_ff @(posedge clock) begin
      if (rdy[ST_ADD]) begin
         sum_ff <= NW'(sqx_ff) + NW'(sqz_ff);
         fl7_ff <= fl6_ff;
         mg7_ff <= mg6_ff;
      end
   end

   // ---------------- square root, one result bit per stage ----------------
   logic [NW-1:0] rt_n_ff  [RW];
   logic [NW-1:0] rt_r_ff  [RW];
   flag_type      rt_fl_ff [RW];
   logic [MW-1:0] rt_mg_ff [RW][3];

   for (genvar k = 0; k < RW; k++) begin : g_root
      localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * k);
      logic [NW-1:0] n_prev;
      logic [NW-1:0] r_prev;
      flag_type      fl_prev;
      logic [MW-1:0] mg_prev [3];
      logic [NW-1:0] trial;
      logic [NW-1:0] n_in;
      logic [NW-1:0] r_in;

      if (k == 0) begin : g_first
         assign n_prev  = sum_ff;
         assign r_prev  = '0;
         assign fl_prev = fl7_ff;
         assign mg_prev = mg7_ff;
      end else begin : g_next
         assign n_prev  = rt_n_ff[k-1];
         assign r_prev  = rt_r_ff[k-1];
         assign fl_prev = rt_fl_ff[k-1];
         assign mg_prev = rt_mg_ff[k-1];
      end

      always_comb begin
         trial = r_prev + BIT;
         if (n_prev >= trial) begin
            n_in = n_prev - trial;
            r_in = (r_prev >> 1) + BIT;
         end else begin
            n_in = n_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[ST_ROOT + k]) begin
            rt_n_ff[k]  <= n_in;
            rt_r_ff[k]  <= r_in;
            rt_fl_ff[k] <= fl_prev;
            rt_mg_ff[k] <= mg_prev;
         end
      end
   end

   // ---------------- normalize: pitch pair (mx, mz), roll pair (my, r) ----------------
   logic [NRM_BITS-1:0] nm_ay_ff [NORM_STEPS];
   logic [NRM_BITS-1:0] nm_ax_ff [NORM_STEPS];
   logic [NRM_BITS-1:0] nm_by_ff [NORM_STEPS];
   logic [NRM_BITS-1:0] nm_bx_ff [NORM_STEPS];
   flag_type            nm_fl_ff [NORM_STEPS];

   for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
      localparam int SH = 16 >> k;
      logic [NRM_BITS-1:0] ay_p, ax_p, by_p, bx_p, a_or, b_or;
      flag_type            fl_p;

      if (k == 0) begin : g_first
         assign ay_p = NRM_BITS'(rt_mg_ff[RW-1][0]);
         assign ax_p = NRM_BITS'(rt_mg_ff[RW-1][2]);
         assign by_p = NRM_BITS'(rt_mg_ff[RW-1][1]);
         assign bx_p = NRM_BITS'(rt_r_ff[RW-1]);
         assign fl_p = rt_fl_ff[RW-1];
      end else begin : g_next
         assign ay_p = nm_ay_ff[k-1];
         assign ax_p = nm_ax_ff[k-1];
         assign by_p = nm_by_ff[k-1];
         assign bx_p = nm_bx_ff[k-1];
         assign fl_p = nm_fl_ff[k-1];
      end

      assign a_or = ay_p | ax_p;
      assign b_or = by_p | bx_p;

      always_ff @(posedge clock) begin
         if (rdy[ST_NORM + k]) begin
            nm_fl_ff[k] <= fl_p;
            if (a_or[NRM_BITS-1 -: SH] == '0) begin
               nm_ay_ff[k] <= ay_p << SH;
               nm_ax_ff[k] <= ax_p << SH;
            end else begin
               nm_ay_ff[k] <= ay_p;
               nm_ax_ff[k] <= ax_p;
            end
            if (b_or[NRM_BITS-1 -: SH] == '0) begin
               nm_by_ff[k] <= by_p << SH;
               nm_bx_ff[k] <= bx_p << SH;
            end else begin
               nm_by_ff[k] <= by_p;
               nm_bx_ff[k] <= bx_p;
            end
         end
      end
   end

   // ---------------- CORDIC vectoring, one step per stage ----------------
   logic signed [CRD_BITS-1:0] cd_ax_ff [CORDIC_STEPS];
   logic signed [CRD_BITS-1:0] cd_ay_ff [CORDIC_STEPS];
   logic signed [ANG_BITS-1:0] cd_az_ff [CORDIC_STEPS];
   logic signed [CRD_BITS-1:0] cd_bx_ff [CORDIC_STEPS];
   logic signed [CRD_BITS-1:0] cd_by_ff [CORDIC_STEPS];
   logic signed [ANG_BITS-1:0] cd_bz_ff [CORDIC_STEPS];
   flag_type                   cd_fl_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cord
      localparam logic signed [ANG_BITS-1:0] ANG = ATAN_TAB[i];
      logic signed [CRD_BITS-1:0] ax_p, ay_p, bx_p, by_p;
      logic signed [ANG_BITS-1:0] az_p, bz_p;
      flag_type                   fl_p;

      if (i == 0) begin : g_first
         assign ax_p = signed'(CRD_BITS'(nm_ax_ff[NORM_STEPS-1]));
         assign ay_p = signed'(CRD_BITS'(nm_ay_ff[NORM_STEPS-1]));
         assign bx_p = signed'(CRD_BITS'(nm_bx_ff[NORM_STEPS-1]));
         assign by_p = signed'(CRD_BITS'(nm_by_ff[NORM_STEPS-1]));
         assign az_p = '0;
         assign bz_p = '0;
         assign fl_p = nm_fl_ff[NORM_STEPS-1];
      end else begin : g_next
         assign ax_p = cd_ax_ff[i-1];
         assign ay_p = cd_ay_ff[i-1];
         assign bx_p = cd_bx_ff[i-1];
         assign by_p = cd_by_ff[i-1];
         assign az_p = cd_az_ff[i-1];
         assign bz_p = cd_bz_ff[i-1];
         assign fl_p = cd_fl_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (rdy[ST_CORD + i]) begin
            cd_fl_ff[i] <= fl_p;
            if (!ay_p[CRD_BITS-1]) begin
               cd_ax_ff[i] <= ax_p + (ay_p >>> i);
               cd_ay_ff[i] <= ay_p - (ax_p >>> i);
               cd_az_ff[i] <= az_p + ANG;
            end else begin
               cd_ax_ff[i] <= ax_p - (ay_p >>> i);
               cd_ay_ff[i] <= ay_p + (ax_p >>> i);
               cd_az_ff[i] <= az_p - ANG;
            end
            if (!by_p[CRD_BITS-1]) begin
               cd_bx_ff[i] <= bx_p + (by_p >>> i);
               cd_by_ff[i] <= by_p - (bx_p >>> i);
               cd_bz_ff[i] <= bz_p + ANG;
            end else begin
               cd_bx_ff[i] <= bx_p - (by_p >>> i);
               cd_by_ff[i] <= by_p + (bx_p >>> i);
               cd_bz_ff[i] <= bz_p - ANG;
            end
         end
      end
   end

   // ---------------- quadrant fixup and output register ----------------
   flag_type           fo;
   logic [13:0]        pitch_m;
   logic [13:0]        roll_m;
   logic signed [15:0] base;
   logic signed [15:0] ax_in;
   logic signed [14:0] ay_in;
   logic signed [15:0] ax_ff;
   logic signed [14:0] ay_ff;
   logic               bad_ff;

   assign fo      = cd_fl_ff[CORDIC_STEPS-1];
   assign pitch_m = to_cdeg(cd_az_ff[CORDIC_STEPS-1]);
   assign roll_m  = to_cdeg(cd_bz_ff[CORDIC_STEPS-1]);
   assign base    = signed'(16'(roll_m));

   always_comb begin
      ay_in = fo.wx_pos ? -signed'(15'(pitch_m)) : signed'(15'(pitch_m));
      if (fo.wz_pos) begin
         ax_in = fo.wy_neg ? -base : base;
      end else if (fo.wz_neg) begin
         ax_in = fo.wy_pos ? base - 16'sd18000 : 16'sd18000 - base;
      end else begin
         ax_in = '0;
      end
      if (fo.bad) begin
         ax_in = '0;
         ay_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_OUT]) begin
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         bad_ff <= fo.bad;
      end
   end

   assign rsp_angle_x = ax_ff;
   assign rsp_angle_y = ay_ff;
   assign rsp_invalid = bad_ff;

   // ---------------- assertions ----------------
   a_drain_frees_input: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[1])
      else $error("accepted item not in first stage");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_angle_x == 0 && rsp_angle_y == 0))
      else $error("invalid item carries nonzero angles");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_y >= -ANGLE_RIGHT && rsp_angle_y <= ANGLE_RIGHT))
      else $error("pitch out of range");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_x >= -ANGLE_HALF && rsp_angle_x <= ANGLE_HALF))
      else $error("roll out of range");

endmodule

`default_nettype wire
